FILE: rtl/aps_pkg.sv
// aps_pkg: shared widths, unit opcodes, request struct and register indexes
// for the adaptive position smoother; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package aps_pkg;

  // shared unit datapath width and multiplier operand width
  localparam int UW    = 66;
  localparam int MBW   = 33;
  localparam int CNT_W = 7;

  // held position and shown position widths
  localparam int POS_W = 40;
  localparam int OUT_W = 24;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TAU   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KNEE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TAU    = 3'd4;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

endpackage

`default_nettype wire

FILE: rtl/aps_if.sv
// aps_in_if and aps_out_if: valid/ready channels of the smoother
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface aps_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] track_id;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic [31:0] time_ms;

  modport source (output valid, track_id, target_x, target_y, time_ms, input ready);
  modport sink   (input valid, track_id, target_x, target_y, time_ms, output ready);
endinterface

interface aps_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic signed [23:0] shown_x;
  logic signed [23:0] shown_y;

  modport source (output valid, accepted, shown_x, shown_y, input ready);
  modport sink   (input valid, accepted, shown_x, shown_y, output ready);
endinterface

`default_nettype wire

FILE: rtl/aps_unit.sv
// aps_unit: bit-serial shared multiply, restoring divide and integer root
// depends on aps_pkg
`timescale 1ns / 1ps
`default_nettype none

module aps_unit
  import aps_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire unit_req_t       req,
  input  wire logic [UW-1:0]   opa,
  input  wire logic [UW-1:0]   opb,
  output logic                 done,
  output logic [UW-1:0]        result
);

  logic             busy;
  unit_op_t         op_r;
  logic [CNT_W-1:0] cnt;
  logic [UW-1:0]    acc;
  logic [UW-1:0]    xs;
  logic [UW-1:0]    ys;
  logic [UW-1:0]    bs;

  logic [UW:0]      rem_div;
  logic [UW+1:0]    rem_sq;
  logic [UW+1:0]    trial;
  logic [UW-1:0]    acc_next;
  logic [UW-1:0]    xs_next;
  logic [UW-1:0]    ys_next;

  // one step of the selected operation
  always_comb begin
    rem_div  = {acc, xs[UW-1]};
    rem_sq   = {acc, xs[UW-1:UW-2]};
    trial    = {ys, 2'b01};
    acc_next = acc;
    xs_next  = xs;
    ys_next  = ys;
    unique case (op_r)
      OP_MUL: begin
        if (ys[0]) acc_next = acc + xs;
        xs_next = xs << 1;
        ys_next = ys >> 1;
      end
      OP_DIV: begin
        xs_next = xs << 1;
        if (rem_div >= {1'b0, bs}) begin
          acc_next = UW'(rem_div - {1'b0, bs});
          ys_next  = {ys[UW-2:0], 1'b1};
        end else begin
          acc_next = rem_div[UW-1:0];
          ys_next  = {ys[UW-2:0], 1'b0};
        end
      end
      OP_SQRT: begin
        xs_next = xs << 2;
        if (rem_sq >= trial) begin
          acc_next = UW'(rem_sq - trial);
          ys_next  = {ys[UW-2:0], 1'b1};
        end else begin
          acc_next = rem_sq[UW-1:0];
          ys_next  = {ys[UW-2:0], 1'b0};
        end
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  // sequencing of the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_r <= OP_MUL;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_r <= req.op;
        cnt  <= (req.op == OP_DIV) ? CNT_W'(UW) : CNT_W'(MBW);
        acc  <= '0;
        xs   <= opa;
        ys   <= (req.op == OP_MUL) ? opb : '0;
        bs   <= opb;
      end else if (busy) begin
        acc <= acc_next;
        xs  <= xs_next;
        ys  <= ys_next;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = (op_r == OP_MUL) ? acc : ys;

endmodule

`default_nettype wire

FILE: rtl/adaptive_position_smoother.sv
// adaptive_position_smoother: speed-adaptive 2D smoothing of one tracked marker
// paths: id zero is rejected from S_CHECK; snapped on id, gap or axis span via S_DONE;
// snapped on distance after the squares and the limit compare; smoothing runs all states
// (one item at a time: a new item is taken only when idle and the output is empty; the
// bit-serial unit does eight multiplies, one root and three divides per smoothed item)
// reset: registers take their defaults, no track is held, output empty; uses aps_pkg, aps_if
`timescale 1ns / 1ps
`default_nettype none

module adaptive_position_smoother
  import aps_pkg::*;
#(
  parameter int POS_FRAC_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  aps_in_if.sink                     in_ch,
  aps_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SH_UP = (POS_FRAC_BITS >= 8) ? POS_FRAC_BITS - 8 : 0;
  localparam int SH_DN = (POS_FRAC_BITS < 8) ? 8 - POS_FRAC_BITS : 0;
  localparam logic [32:0] HALF_IN = (33'd1 << SH_DN) >> 1;
  localparam logic [POS_W:0] HALF_OUT = ((POS_W+1)'(1) << POS_FRAC_BITS) >> 1;
  localparam int LIM_W = 16 + POS_FRAC_BITS;
  localparam int AW    = 32 + POS_FRAC_BITS;
  localparam int BW    = 43;
  localparam int DW    = 33;
  localparam logic [OUT_W:0] SAT_POS = 25'd8388607;
  localparam logic [OUT_W:0] SAT_NEG = 25'd8388608;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SQX, S_SQY, S_LIM, S_SQRT, S_A, S_B,
    S_NUM, S_TAU, S_BX, S_DX, S_BY, S_DY, S_DONE
  } state_t;

  // target conversion to held position format
  function automatic logic [POS_W-1:0] to_pos(input logic [31:0] raw);
    logic [32:0] mag;
    logic [32:0] rnd;
    mag = raw[31] ? (33'd0 - {1'b1, raw}) : {1'b0, raw};
    rnd = (mag + HALF_IN) >> SH_DN;
    if (POS_FRAC_BITS >= 8) to_pos = {{(POS_W-32){raw[31]}}, raw} << SH_UP;
    else to_pos = raw[31] ? (POS_W'(0) - POS_W'(rnd)) : POS_W'(rnd);
  endfunction

  // whole pixels, rounded half away from zero, saturated
  function automatic logic [OUT_W-1:0] show(input logic [POS_W-1:0] p);
    logic [POS_W:0] mag;
    logic [POS_W:0] r;
    mag = p[POS_W-1] ? ((POS_W+1)'(0) - {p[POS_W-1], p}) : {1'b0, p};
    r   = (mag + HALF_OUT) >> POS_FRAC_BITS;
    if (!p[POS_W-1]) show = (r > (POS_W+1)'(SAT_POS)) ? SAT_POS[OUT_W-1:0] : r[OUT_W-1:0];
    else if (r > (POS_W+1)'(SAT_NEG)) show = SAT_NEG[OUT_W-1:0];
    else show = OUT_W'(0) - r[OUT_W-1:0];
  endfunction

  // configuration registers
  logic [15:0] max_gap, jump_limit, base_tau, speed_knee, min_tau;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap    <= 16'd120;
      jump_limit <= 16'd300;
      base_tau   <= 16'd4608;
      speed_knee <= 16'd400;
      min_tau    <= 16'd384;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_MAX_GAP:    max_gap    <= cfg_data;
        REG_JUMP_LIMIT: jump_limit <= cfg_data;
        REG_BASE_TAU:   base_tau   <= cfg_data;
        REG_SPEED_KNEE: speed_knee <= cfg_data;
        REG_MIN_TAU:    min_tau    <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state;
  logic   started;

  // track state
  logic              track_valid;
  logic [63:0]       held_id;
  logic [31:0]       last_time;
  logic [POS_W-1:0]  pos_x, pos_y;

  // item registers
  logic [63:0]       id;
  logic [POS_W-1:0]  tx, ty;
  logic [31:0]       now;
  logic [15:0]       elapsed;
  logic [POS_W:0]    adx, ady;
  logic              sgx, sgy;
  logic              snap;
  logic [UW-1:0]     sum, num, prod;
  logic [DW-1:0]     root;
  logic [AW-1:0]     areg;
  logic [BW-1:0]     breg;
  logic [24:0]       den;
  logic [POS_W-1:0]  nx, ny;

  // output register
  logic              ov, oacc;
  logic [OUT_W-1:0]  osx, osy;

  // combinational helpers
  logic [31:0]       gap;
  logic [POS_W:0]    dxc, dyc;
  logic [LIM_W-1:0]  lim;
  logic [15:0]       knee;
  logic [23:0]       e;
  logic [15:0]       tau_q, tau_c;
  logic [DW-1:0]     mag;

  // shared unit
  unit_req_t         req;
  logic [UW-1:0]     opa, opb, result;
  logic              done;

  assign gap   = now - last_time;
  assign dxc   = {tx[POS_W-1], tx} - {pos_x[POS_W-1], pos_x};
  assign dyc   = {ty[POS_W-1], ty} - {pos_y[POS_W-1], pos_y};
  assign lim   = LIM_W'(jump_limit) << POS_FRAC_BITS;
  assign knee  = (speed_knee == 16'd0) ? 16'd1 : speed_knee;
  assign e     = {elapsed, 8'd0};
  assign tau_q = result[15:0];
  assign tau_c = (tau_q < min_tau) ? min_tau : tau_q;
  assign mag   = result[DW-1:0];

  // operand selection for the shared unit
  always_comb begin
    req.start = 1'b0;
    req.op    = OP_MUL;
    opa       = '0;
    opb       = '0;
    unique case (state)
      S_SQX:  begin opa = UW'(adx); opb = UW'(adx); end
      S_SQY:  begin opa = UW'(ady); opb = UW'(ady); end
      S_LIM:  begin opa = UW'(lim); opb = UW'(lim); end
      S_SQRT: begin req.op = OP_SQRT; opa = sum; end
      S_A:    begin opa = UW'(knee); opb = UW'(elapsed); end
      S_B:    begin opa = UW'(root); opb = UW'(10'd1000); end
      S_NUM:  begin opa = UW'(areg); opb = UW'(base_tau); end
      S_TAU:  begin req.op = OP_DIV; opa = num; opb = UW'(areg) + UW'(breg); end
      S_BX:   begin opa = UW'(adx); opb = UW'(e); end
      S_DX:   begin req.op = OP_DIV; opa = prod + UW'(den >> 1); opb = UW'(den); end
      S_BY:   begin opa = UW'(ady); opb = UW'(e); end
      S_DY:   begin req.op = OP_DIV; opa = prod + UW'(den >> 1); opb = UW'(den); end
      default: begin opa = '0; end
    endcase
    if (state != S_IDLE && state != S_CHECK && state != S_DONE) req.start = !started;
  end

  aps_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .done   (done),
    .result (result)
  );

  assign in_ch.ready     = (state == S_IDLE) && !ov;
  assign out_ch.valid    = ov;
  assign out_ch.accepted = oacc;
  assign out_ch.shown_x  = osx;
  assign out_ch.shown_y  = osy;

  // sequencer, track state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      started     <= 1'b0;
      track_valid <= 1'b0;
      held_id     <= '0;
      last_time   <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
      ov          <= 1'b0;
    end else begin
      if (ov && out_ch.ready) ov <= 1'b0;
      if (req.start) started <= 1'b1;
      if (done) started <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            id    <= in_ch.track_id;
            tx    <= to_pos(in_ch.target_x);
            ty    <= to_pos(in_ch.target_y);
            now   <= in_ch.time_ms;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          elapsed <= gap[15:0];
          adx     <= dxc[POS_W] ? ((POS_W+1)'(0) - dxc) : dxc;
          ady     <= dyc[POS_W] ? ((POS_W+1)'(0) - dyc) : dyc;
          sgx     <= dxc[POS_W];
          sgy     <= dyc[POS_W];
          if (id == 64'd0) begin
            snap  <= 1'b1;
            ov    <= 1'b1;
            oacc  <= 1'b0;
            osx   <= '0;
            osy   <= '0;
            state <= S_IDLE;
          end else if (!track_valid || held_id != id || gap > 32'(max_gap) || gap == 32'd0) begin
            snap  <= 1'b1;
            state <= S_DONE;
          end else if ((dxc[POS_W] ? ((POS_W+1)'(0) - dxc) : dxc) > (POS_W+1)'(lim) ||
                       (dyc[POS_W] ? ((POS_W+1)'(0) - dyc) : dyc) > (POS_W+1)'(lim)) begin
            snap  <= 1'b1;
            state <= S_DONE;
          end else begin
            snap  <= 1'b0;
            state <= S_SQX;
          end
        end
        S_SQX: if (done) begin sum <= result; state <= S_SQY; end
        S_SQY: if (done) begin sum <= sum + result; state <= S_LIM; end
        S_LIM: begin
          if (done) begin
            if (sum > result) begin
              snap  <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: if (done) begin root <= result[DW-1:0]; state <= S_A; end
        S_A: if (done) begin areg <= AW'(result[31:0]) << POS_FRAC_BITS; state <= S_B; end
        S_B: if (done) begin breg <= result[BW-1:0]; state <= S_NUM; end
        S_NUM: if (done) begin num <= result; state <= S_TAU; end
        S_TAU: if (done) begin den <= 25'(e) + 25'(tau_c); state <= S_BX; end
        S_BX: if (done) begin prod <= result; state <= S_DX; end
        S_DX: begin
          if (done) begin
            nx    <= sgx ? (pos_x - POS_W'(mag)) : (pos_x + POS_W'(mag));
            state <= S_BY;
          end
        end
        S_BY: if (done) begin prod <= result; state <= S_DY; end
        S_DY: begin
          if (done) begin
            ny    <= sgy ? (pos_y - POS_W'(mag)) : (pos_y + POS_W'(mag));
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // commit the new position and publish the result
          pos_x       <= snap ? tx : nx;
          pos_y       <= snap ? ty : ny;
          held_id     <= id;
          track_valid <= 1'b1;
          last_time   <= now;
          ov          <= 1'b1;
          oacc        <= 1'b1;
          osx         <= show(snap ? tx : nx);
          osy         <= show(snap ? ty : ny);
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
